// ===== hdl/apsc_pkg.sv =====
// shared constants and types for the averaged piecewise sensor calibrator
// no dependencies; imported by the divider, the core and the checker
`default_nettype none

package apsc_pkg;

  localparam int unsigned MaxWindowDef = 16;
  localparam int unsigned MaxPointsDef = 8;
  localparam int unsigned ValueBitsDef = 24;

  localparam int unsigned CfgWidth     = 5;
  localparam logic [CfgWidth-1:0] WinLenReset = 5'd10;

  // register index of the window length
  localparam logic RegWinLen = 1'b0;

  typedef enum logic [2:0] {
    ACT_SAMPLE  = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_TARE    = 3'd3,
    ACT_UNTARE  = 3'd4
  } action_e;

endpackage

`default_nettype wire

// ===== hdl/apsc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module apsc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apsc_div.sv =====
// serial restoring divider, one quotient bit per cycle, rounded to nearest
// with ties away from zero; uses apsc_pkg
`default_nettype none

module apsc_div #(
  parameter int unsigned NW = 50,
  parameter int unsigned DW = 25
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic      [NW:0]   quo_o
);
  import apsc_pkg::*;

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DW-1:0]   den_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DW:0]     shifted;
  logic            take;
  logic            round_up;

  assign shifted  = {rem_q, num_q[NW-1]};
  assign take     = (shifted >= {1'b0, den_q});
  assign round_up = ({rem_q, 1'b0} >= {1'b0, den_q});
  assign quo_o    = {1'b0, num_q} + {{NW{1'b0}}, round_up};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
      num_q <= {num_q[NW-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/averaged_piecewise_sensor_calibrator_core.sv =====
// Averaged piecewise sensor calibrator: moving-window mean of signed samples,
// mapped through a sorted table of calibration points, then tared.
//
// Input channel in_valid_i/in_stall_o carries one request: an action code and
// its operands. Every request gives exactly one result on out_valid_o/
// out_stall_i. A request is taken when in_valid_i is high and in_stall_o low;
// the block handles one request at a time and raises in_stall_o meanwhile.
// Clear, tare, untare and an add on a full table go straight to the result.
// Add point steps through the stored points to find its slot. A sample
// reads and writes its window slot, re-sums the whole window when the slot
// wraps, runs the mean divide and, with two or more points stored, the
// segment search, the serial multiply and the interpolation divide, then
// registers the result. The two bit-serial divides are the longest steps.
// A finished result sits in the output register while a new request is
// accepted; if the receiver still stalls when the next result is ready, the
// block waits with in_stall_o high. Reset empties the window and the table,
// zeroes the mean, mapped value and tare, and sets the window length to 10.
// The user writes the window length over the APB port only while the block
// is idle; the block itself does not enforce this.
`default_nettype none

module averaged_piecewise_sensor_calibrator_core #(
  parameter int unsigned MAX_WINDOW = apsc_pkg::MaxWindowDef,
  parameter int unsigned MAX_POINTS = apsc_pkg::MaxPointsDef,
  parameter int unsigned VALUE_BITS = apsc_pkg::ValueBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [2:0]                           action_i,
  input  wire logic signed [VALUE_BITS-1:0]         sample_i,
  input  wire logic signed [VALUE_BITS-1:0]         point_raw_i,
  input  wire logic signed [VALUE_BITS-1:0]         point_real_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [VALUE_BITS-1:0]              tared_value_o,
  output logic signed [VALUE_BITS-1:0]              averaged_raw_o,
  output logic signed [VALUE_BITS-1:0]              calibrated_value_o,
  output logic signed [VALUE_BITS-1:0]              tare_offset_o,
  output logic      [$clog2(MAX_POINTS+1)-1:0]      point_count_o,
  output logic                                      accepted_o
);
  import apsc_pkg::*;

  localparam int unsigned VB   = VALUE_BITS;
  localparam int unsigned AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUMW = VB + AW + 1;
  localparam int unsigned DW   = VB + 1;
  localparam int unsigned NW   = 2 * VB + 2;
  localparam int unsigned MW   = VB + 1;
  localparam int unsigned MCW  = $clog2(MW + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_UPD   = 4'd2;
  localparam logic [3:0] ST_RSUM  = 4'd3;
  localparam logic [3:0] ST_MEAN  = 4'd4;
  localparam logic [3:0] ST_MWAIT = 4'd5;
  localparam logic [3:0] ST_SCAN  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_IDIV  = 4'd8;
  localparam logic [3:0] ST_IWAIT = 4'd9;
  localparam logic [3:0] ST_ADD   = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  localparam logic signed [VB-1:0] VMax = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMin = {1'b1, {(VB-1){1'b0}}};

  // base plus or minus a wide magnitude, saturated to the value range
  function automatic logic signed [VB-1:0] sat_add(logic signed [VB-1:0] base,
                                                  logic [NW:0] q, logic neg);
    logic signed [VB+1:0] t;
    logic                 big;
    big = |q[NW:VB];
    if (neg) begin
      t = $signed({{2{base[VB-1]}}, base}) - $signed({2'b00, q[VB-1:0]});
    end else begin
      t = $signed({{2{base[VB-1]}}, base}) + $signed({2'b00, q[VB-1:0]});
    end
    if (big) begin
      return neg ? VMin : VMax;
    end else if (t > $signed({3'b000, {(VB-1){1'b1}}})) begin
      return VMax;
    end else if (t < $signed({3'b111, {(VB-1){1'b0}}})) begin
      return VMin;
    end
    return t[VB-1:0];
  endfunction

  logic [3:0]              state_q, state_d;
  logic [CfgWidth-1:0]     wlen_q;
  logic [SW-1:0]           len;
  logic [SW-1:0]           slot_q, slot_nx;
  logic [SW-1:0]           k_q;
  logic                    pend_q;
  logic signed [SUMW-1:0]  sum_q;
  logic [SUMW-1:0]         sum_mag;
  logic signed [VB-1:0]    mean_q, mapped_q, zoff_q;
  logic [CW-1:0]           tcnt_q, idx_q, pos_q;
  logic                    acc_q;
  logic [2:0]              act;
  logic signed [VB-1:0]    smp_q, preal_q;
  logic [MAX_WINDOW-1:0]   wvld_q;
  logic                    rvld_q;
  logic                    ram_re, ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [VB-1:0]           ram_rdata;
  logic signed [VB-1:0]    old_val;

  logic signed [VB-1:0]    traw_q  [MAX_POINTS];
  logic signed [VB-1:0]    treal_q [MAX_POINTS];
  logic signed [VB-1:0]    e_raw, e_real;
  logic signed [VB-1:0]    prev_raw_q, prev_real_q;
  logic                    hit, last;
  logic signed [VB-1:0]    anc_raw, anc_real;
  logic signed [VB:0]      dx, dy, dn;
  logic signed [VB-1:0]    anc_q;
  logic                    neg_q;
  logic [NW-1:0]           mcand_q, prod_q;
  logic [MW-1:0]           mplier_q;
  logic [MCW-1:0]          mcnt_q;
  logic [DW-1:0]           den_q;

  logic                    div_start, div_done;
  logic [NW-1:0]           div_num;
  logic [DW-1:0]           div_den;
  logic [NW:0]             div_quo;

  logic                    accept, fin_go, do_insert;
  logic signed [VB:0]      tare_diff;
  logic signed [VB-1:0]    tared;

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegWinLen) begin
      prdata = {{(32-CfgWidth){1'b0}}, wlen_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WinLenReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegWinLen)) begin
      wlen_q <= pwdata[CfgWidth-1:0];
    end
  end

  always_comb begin
    if (wlen_q == '0) begin
      len = SW'(1);
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      len = SW'(MAX_WINDOW);
    end else begin
      len = SW'(wlen_q);
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign act        = action_i;
  assign fin_go     = (state_q == ST_FIN) && (!out_valid_o || !out_stall_i);

  // window store
  assign ram_re    = (state_q == ST_RD) || ((state_q == ST_RSUM) && (k_q < len));
  assign ram_raddr = (state_q == ST_RSUM) ? k_q[AW-1:0] : slot_q[AW-1:0];
  assign ram_we    = (state_q == ST_UPD);
  assign old_val   = rvld_q ? $signed(ram_rdata) : '0;
  assign slot_nx   = slot_q + 1'b1;

  apsc_ram #(
    .WIDTH(VB),
    .DEPTH(MAX_WINDOW)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q[AW-1:0]),
    .wdata_i(smp_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ram_we) begin
        wvld_q[slot_q[AW-1:0]] <= 1'b1;
      end
      if (ram_re) begin
        rvld_q <= wvld_q[ram_raddr];
      end
    end
  end

  assign sum_mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

  // table entry under the scan index
  assign e_raw  = traw_q[idx_q[PW-1:0]];
  assign e_real = treal_q[idx_q[PW-1:0]];
  assign hit    = (e_raw >= mean_q);
  assign last   = (idx_q == tcnt_q - 1'b1);

  always_comb begin
    anc_raw  = hit ? prev_raw_q : e_raw;
    anc_real = hit ? prev_real_q : e_real;
    dx = $signed({mean_q[VB-1], mean_q}) - $signed({anc_raw[VB-1], anc_raw});
    dy = $signed({e_real[VB-1], e_real}) - $signed({prev_real_q[VB-1], prev_real_q});
    dn = $signed({e_raw[VB-1], e_raw}) - $signed({prev_raw_q[VB-1], prev_raw_q});
  end

  assign div_start = (state_q == ST_MEAN) || (state_q == ST_IDIV);
  assign div_num   = (state_q == ST_MEAN) ? NW'(sum_mag) : prod_q;
  assign div_den   = (state_q == ST_MEAN) ? DW'(len) : den_q;

  apsc_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign do_insert = (state_q == ST_ADD) && (idx_q == tcnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_SAMPLE: state_d = ST_RD;
            ACT_ADD:    state_d = (32'(tcnt_q) >= MAX_POINTS) ? ST_FIN : ST_ADD;
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_RD:    state_d = ST_UPD;
      ST_UPD:   state_d = (slot_nx >= len) ? ST_RSUM : ST_MEAN;
      ST_RSUM:  state_d = (!(k_q < len) && !pend_q) ? ST_MEAN : ST_RSUM;
      ST_MEAN:  state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (div_done) begin
          state_d = (tcnt_q < CW'(2)) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((idx_q != '0) && (hit || last)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = (mcnt_q == '0) ? ST_IDIV : ST_MUL;
      ST_IDIV:  state_d = ST_IWAIT;
      ST_IWAIT: state_d = div_done ? ST_FIN : ST_IWAIT;
      ST_ADD: begin
        if (do_insert || (e_raw == smp_q)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:   state_d = fin_go ? ST_IDLE : ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      slot_q   <= '0;
      sum_q    <= '0;
      mean_q   <= '0;
      mapped_q <= '0;
      zoff_q   <= '0;
      tcnt_q   <= '0;
      acc_q    <= 1'b0;
      idx_q    <= '0;
      pos_q    <= '0;
      k_q      <= '0;
      pend_q   <= 1'b0;
      mcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          acc_q <= 1'b0;
          idx_q <= '0;
          pos_q <= '0;
          if (accept) begin
            case (act)
              ACT_CLEAR: begin
                tcnt_q <= '0;
                zoff_q <= '0;
              end
              ACT_TARE:   zoff_q <= mapped_q;
              ACT_UNTARE: zoff_q <= '0;
              default: ;
            endcase
          end
        end
        ST_UPD: begin
          if (slot_nx >= len) begin
            slot_q <= '0;
            sum_q  <= '0;
            k_q    <= '0;
            pend_q <= 1'b0;
          end else begin
            slot_q <= slot_nx;
            sum_q  <= sum_q - SUMW'(old_val) + SUMW'(smp_q);
          end
        end
        ST_RSUM: begin
          // read data arrives in the cycle after its address
          if (pend_q) begin
            sum_q <= sum_q + SUMW'(old_val);
          end
          pend_q <= (k_q < len);
          if (k_q < len) begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_MWAIT: begin
          if (div_done) begin
            mean_q <= sat_add('0, div_quo, sum_q[SUMW-1]);
            if (tcnt_q < CW'(2)) begin
              mapped_q <= sat_add('0, div_quo, sum_q[SUMW-1]);
            end
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q + 1'b1;
        end
        ST_MUL: begin
          mcnt_q <= mcnt_q - 1'b1;
        end
        ST_IWAIT: begin
          if (div_done) begin
            mapped_q <= sat_add(anc_q, div_quo, neg_q);
          end
        end
        ST_ADD: begin
          if (do_insert) begin
            tcnt_q <= tcnt_q + 1'b1;
            acc_q  <= 1'b1;
          end else if (e_raw != smp_q) begin
            if (e_raw < smp_q) begin
              pos_q <= pos_q + 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        default: ;
      endcase
      if ((state_q == ST_SCAN) && (idx_q != '0) && (hit || last)) begin
        mcnt_q <= MCW'(MW);
      end
    end
  end

  // operand and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q   <= (act == ACT_ADD) ? point_raw_i : sample_i;
      preal_q <= point_real_i;
    end
    if (state_q == ST_SCAN) begin
      prev_raw_q  <= e_raw;
      prev_real_q <= e_real;
      if ((idx_q != '0) && (hit || last)) begin
        anc_q    <= anc_real;
        neg_q    <= dx[VB] ^ dy[VB];
        mcand_q  <= NW'(dx[VB] ? MW'(-dx) : MW'(dx));
        mplier_q <= dy[VB] ? MW'(-dy) : MW'(dy);
        den_q    <= DW'(dn);
        prod_q   <= '0;
      end
    end
    if ((state_q == ST_MUL) && (mcnt_q != '0)) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[NW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MW-1:1]};
    end
  end

  // sorted insert: entries above the slot move up by one
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      if (pos_q == '0) begin
        traw_q[0]  <= smp_q;
        treal_q[0] <= preal_q;
      end
      for (int j = 1; j < MAX_POINTS; j++) begin
        if (CW'(j) == pos_q) begin
          traw_q[j]  <= smp_q;
          treal_q[j] <= preal_q;
        end else if (CW'(j) > pos_q) begin
          traw_q[j]  <= traw_q[j-1];
          treal_q[j] <= treal_q[j-1];
        end
      end
    end
  end

  always_comb begin
    tare_diff = $signed({mapped_q[VB-1], mapped_q}) - $signed({zoff_q[VB-1], zoff_q});
    if (tare_diff > $signed({2'b00, {(VB-1){1'b1}}})) begin
      tared = VMax;
    end else if (tare_diff < $signed({2'b11, {(VB-1){1'b0}}})) begin
      tared = VMin;
    end else begin
      tared = tare_diff[VB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fin_go) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      tared_value_o      <= tared;
      averaged_raw_o     <= mean_q;
      calibrated_value_o <= mapped_q;
      tare_offset_o      <= zoff_q;
      point_count_o      <= tcnt_q;
      accepted_o         <= acc_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apsc_checker.sv =====
// port-level checks for the calibrator core, attached by bind
// uses apsc_pkg; bound to averaged_piecewise_sensor_calibrator_core
`default_nettype none

module apsc_checker #(
  parameter int unsigned MAX_POINTS = apsc_pkg::MaxPointsDef,
  parameter int unsigned VALUE_BITS = apsc_pkg::ValueBitsDef
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [VALUE_BITS-1:0]           tared_value_o,
  input wire logic [VALUE_BITS-1:0]           calibrated_value_o,
  input wire logic [VALUE_BITS-1:0]           tare_offset_o,
  input wire logic [$clog2(MAX_POINTS+1)-1:0] point_count_o,
  input wire logic                            accepted_o
);
  import apsc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tared_value_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(point_count_o) <= MAX_POINTS)
    else $error("point count beyond table size");

  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> point_count_o != '0)
    else $error("accepted point but empty table");

  a_no_tare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tare_offset_o == '0) |-> tared_value_o == calibrated_value_o)
    else $error("tared value differs with zero tare");

endmodule

bind averaged_piecewise_sensor_calibrator_core apsc_checker #(
  .MAX_POINTS(MAX_POINTS),
  .VALUE_BITS(VALUE_BITS)
) u_apsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .tared_value_o     (tared_value_o),
  .calibrated_value_o(calibrated_value_o),
  .tare_offset_o     (tare_offset_o),
  .point_count_o     (point_count_o),
  .accepted_o        (accepted_o)
);

`default_nettype wire
